>>> rtl/onmc_pkg.sv
// Shared types, constants and helper functions for the octree node mirror canonicalizer.
`default_nettype none

package onmc_pkg;

    localparam int N_CHILD       = 8;
    localparam int FLIP_W        = 3;
    localparam int MASK_W        = 8;
    localparam int COUNT_W       = 4;
    localparam int FIELD_W       = 32;
    localparam int CHILD_W_DEF   = 32;

    // stream payload widths
    localparam int IN_TDATA_W    = MASK_W + N_CHILD * FIELD_W;                    // 264
    localparam int OUT_RAW_W     = FLIP_W + MASK_W + COUNT_W + N_CHILD * FIELD_W; // 271
    localparam int OUT_TDATA_W   = ((OUT_RAW_W + 7) / 8) * 8;                     // 272

    localparam logic [7:0] M_X_HI = 8'b1010_1010;
    localparam logic [7:0] M_X_LO = 8'b0101_0101;
    localparam logic [7:0] M_Y_HI = 8'b1100_1100;
    localparam logic [7:0] M_Y_LO = 8'b0011_0011;
    localparam logic [7:0] M_Z_HI = 8'b1111_0000;
    localparam logic [7:0] M_Z_LO = 8'b0000_1111;

    typedef logic [FLIP_W-1:0] t_flip;

    typedef enum logic {
        OP_INTERIOR = 1'b0,
        OP_LEAF     = 1'b1
    } t_opcode;

    // Mirror an 8-bit child mask along the axes set in f.
    function automatic logic [7:0] mirror_mask(input logic [7:0] m, input t_flip f);
        logic [7:0] r;
        r = m;
        if (f[0]) r = ((r & M_X_HI) >> 1) | ((r & M_X_LO) << 1);
        if (f[1]) r = ((r & M_Y_HI) >> 2) | ((r & M_Y_LO) << 2);
        if (f[2]) r = ((r & M_Z_HI) >> 4) | ((r & M_Z_LO) << 4);
        return r;
    endfunction

    // Transform one child value under flip f (value already limited to child width).
    function automatic logic [FIELD_W-1:0] xform_val(input t_opcode op,
                                                     input logic [FIELD_W-1:0] v,
                                                     input t_flip f);
        logic [FIELD_W-1:0] r;
        if (op == OP_LEAF) begin
            r = FIELD_W'(mirror_mask(v[7:0], f));
        end else begin
            r = v ^ FIELD_W'(f);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/onmc_cmp.sv
// Lexicographic compare of the child sequences of one node under two flips.
`default_nettype none

module onmc_cmp #(
    parameter int CHILD_WIDTH = onmc_pkg::CHILD_W_DEF
) (
    input  wire logic                   i_opcode,
    input  wire logic [7:0]             i_mask,
    input  wire logic [CHILD_WIDTH-1:0] i_vals [onmc_pkg::N_CHILD],
    input  wire onmc_pkg::t_flip        i_flip_a,
    input  wire onmc_pkg::t_flip        i_flip_b,
    output onmc_pkg::t_flip             o_flip
);
    import onmc_pkg::*;

    // key MSB set = absent child, ranks above every value
    logic [CHILD_WIDTH:0] w_key_a [N_CHILD];
    logic [CHILD_WIDTH:0] w_key_b [N_CHILD];
    logic                 w_b_wins;

    for (genvar gi = 0; gi < N_CHILD; gi++) begin : g_key
        logic [FLIP_W-1:0] w_src_a, w_src_b;
        assign w_src_a = FLIP_W'(gi) ^ i_flip_a;
        assign w_src_b = FLIP_W'(gi) ^ i_flip_b;
        assign w_key_a[gi] = i_mask[w_src_a]
            ? {1'b0, CHILD_WIDTH'(xform_val(t_opcode'(i_opcode),
                                            FIELD_W'(i_vals[w_src_a]), i_flip_a))}
            : {1'b1, {CHILD_WIDTH{1'b0}}};
        assign w_key_b[gi] = i_mask[w_src_b]
            ? {1'b0, CHILD_WIDTH'(xform_val(t_opcode'(i_opcode),
                                            FIELD_W'(i_vals[w_src_b]), i_flip_b))}
            : {1'b1, {CHILD_WIDTH{1'b0}}};
    end

    // first differing slot decides; ties keep flip a
    always_comb begin
        logic done;
        done     = 1'b0;
        w_b_wins = 1'b0;
        for (int i = 0; i < N_CHILD; i++) begin
            if (!done && (w_key_a[i] != w_key_b[i])) begin
                w_b_wins = (w_key_b[i] < w_key_a[i]);
                done     = 1'b1;
            end
        end
    end

    assign o_flip = w_b_wins ? i_flip_b : i_flip_a;

endmodule

`default_nettype wire

>>> rtl/onmc_xform.sv
// Applies the chosen flip: mirrored mask and transformed child per slot.
`default_nettype none

module onmc_xform #(
    parameter int CHILD_WIDTH = onmc_pkg::CHILD_W_DEF
) (
    input  wire logic                   i_opcode,
    input  wire logic [7:0]             i_mask,
    input  wire logic [CHILD_WIDTH-1:0] i_vals [onmc_pkg::N_CHILD],
    input  wire onmc_pkg::t_flip        i_flip,
    output logic [7:0]                  o_cmask,
    output logic [CHILD_WIDTH-1:0]      o_slot [onmc_pkg::N_CHILD]
);
    import onmc_pkg::*;

    assign o_cmask = mirror_mask(i_mask, i_flip);

    for (genvar gi = 0; gi < N_CHILD; gi++) begin : g_slot
        logic [FLIP_W-1:0] w_src;
        assign w_src      = FLIP_W'(gi) ^ i_flip;
        assign o_slot[gi] = CHILD_WIDTH'(xform_val(t_opcode'(i_opcode),
                                                   FIELD_W'(i_vals[w_src]), i_flip));
    end

endmodule

`default_nettype wire

>>> rtl/onmc_compact.sv
// Packs the present slots in order and counts them.
`default_nettype none

module onmc_compact #(
    parameter int CHILD_WIDTH = onmc_pkg::CHILD_W_DEF
) (
    input  wire logic [7:0]                     i_cmask,
    input  wire logic [CHILD_WIDTH-1:0]         i_slot [onmc_pkg::N_CHILD],
    output logic [onmc_pkg::COUNT_W-1:0]        o_count,
    output logic [onmc_pkg::FIELD_W-1:0]        o_packed [onmc_pkg::N_CHILD]
);
    import onmc_pkg::*;

    always_comb begin
        logic [COUNT_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < N_CHILD; i++) o_packed[i] = '0;
        for (int i = 0; i < N_CHILD; i++) begin
            if (i_cmask[i]) begin
                o_packed[pos[FLIP_W-1:0]] = FIELD_W'(i_slot[i]);
                pos = pos + COUNT_W'(1);
            end
        end
        o_count = pos;
    end

endmodule

`default_nettype wire

>>> rtl/octree_node_mirror_canonicalizer_top.sv
// Top level of the octree node mirror canonicalizer pipeline.
`default_nettype none

// Usage
//   Slave stream takes one octree node per item: tuser[0] is the opcode
//   (0 interior, 1 leaf-level), tdata holds the occupancy mask and eight
//   child values. Master stream returns one item per node: chosen flip,
//   canonical mask, child count and the packed transformed children.
// Pipeline: six register stages (input register, three tournament levels of flip
//   compares, transform, compaction/output).
// Throughput: one item per cycle while i_m_axis_tready stays high. Each of the
//   six stages holds its own valid bit; a stage loads whenever it is empty or
//   the stage after it moves, so bubbles collapse and the pipe keeps taking
//   items while a result waits.
// Stall: when i_m_axis_tready is low the output holds steady; upstream stages
//   fill up and o_s_axis_tready drops only once every stage holds an item.
// Reset: synchronous, active low; clears all valid bits, payload is don't care.
// The critical path is one flip-pair compare: eight (CHILD_WIDTH+1)-bit
//   magnitude compares plus a first-difference priority pick.

module octree_node_mirror_canonicalizer_top #(
    parameter int CHILD_WIDTH = onmc_pkg::CHILD_W_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // [7:0] occupancy_mask, [39:8] child_0 ... [263:232] child_7
    input  wire logic [onmc_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [0] opcode
    input  wire logic [0:0]                       i_s_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // [2:0] chosen_flip, [10:3] canonical_mask, [14:11] child_count,
    // [46:15] packed_0 ... [270:239] packed_7, [271] zero
    output logic [onmc_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata
);
    import onmc_pkg::*;

    localparam int NS = 6;

    logic [NS-1:0] r_v;
    logic [NS-1:0] w_rdy;

    // stage ready chain: load when empty or when the next stage moves
    always_comb begin
        w_rdy[NS-1] = !r_v[NS-1] || i_m_axis_tready;
        for (int k = NS-2; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign o_s_axis_tready = w_rdy[0];
    assign o_m_axis_tvalid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) r_v[0] <= i_s_axis_tvalid;
            for (int k = 1; k < NS; k++) begin
                if (w_rdy[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // node payload travels through stages 0..3
    logic                   r_op   [4];
    logic [7:0]             r_mask [4];
    logic [CHILD_WIDTH-1:0] r_vals [4][N_CHILD];

    t_flip r_f1 [4];
    t_flip r_f2 [2];
    t_flip r_f3;

    t_flip w_f1 [4];
    t_flip w_f2 [2];
    t_flip w_f3;

    // stage 0: input register, children trimmed to CHILD_WIDTH
    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_op[0]   <= i_s_axis_tuser[0];
            r_mask[0] <= i_s_axis_tdata[MASK_W-1:0];
            for (int i = 0; i < N_CHILD; i++) begin
                r_vals[0][i] <= i_s_axis_tdata[MASK_W + i*FIELD_W +: CHILD_WIDTH];
            end
        end
    end

    // stage 1: flips 0/1, 2/3, 4/5, 6/7
    for (genvar gk = 0; gk < 4; gk++) begin : g_l1
        onmc_cmp #(.CHILD_WIDTH(CHILD_WIDTH)) u_cmp (
            .i_opcode (r_op[0]),
            .i_mask   (r_mask[0]),
            .i_vals   (r_vals[0]),
            .i_flip_a (FLIP_W'(2*gk)),
            .i_flip_b (FLIP_W'(2*gk+1)),
            .o_flip   (w_f1[gk])
        );
    end

    // stage 2: pairs of stage 1 winners
    for (genvar gk = 0; gk < 2; gk++) begin : g_l2
        onmc_cmp #(.CHILD_WIDTH(CHILD_WIDTH)) u_cmp (
            .i_opcode (r_op[1]),
            .i_mask   (r_mask[1]),
            .i_vals   (r_vals[1]),
            .i_flip_a (r_f1[2*gk]),
            .i_flip_b (r_f1[2*gk+1]),
            .o_flip   (w_f2[gk])
        );
    end

    // stage 3: final winner; lower flip always sits on the a side
    onmc_cmp #(.CHILD_WIDTH(CHILD_WIDTH)) u_cmp_l3 (
        .i_opcode (r_op[2]),
        .i_mask   (r_mask[2]),
        .i_vals   (r_vals[2]),
        .i_flip_a (r_f2[0]),
        .i_flip_b (r_f2[1]),
        .o_flip   (w_f3)
    );

    always_ff @(posedge i_clk) begin
        for (int k = 1; k < 4; k++) begin
            if (w_rdy[k]) begin
                r_op[k]   <= r_op[k-1];
                r_mask[k] <= r_mask[k-1];
                r_vals[k] <= r_vals[k-1];
            end
        end
        if (w_rdy[1]) r_f1 <= w_f1;
        if (w_rdy[2]) r_f2 <= w_f2;
        if (w_rdy[3]) r_f3 <= w_f3;
    end

    // stage 4: apply chosen flip
    logic [7:0]             w_cmask;
    logic [CHILD_WIDTH-1:0] w_slot [N_CHILD];
    logic [7:0]             r_cmask;
    logic [CHILD_WIDTH-1:0] r_slot [N_CHILD];
    t_flip                  r_f4;

    onmc_xform #(.CHILD_WIDTH(CHILD_WIDTH)) u_xform (
        .i_opcode (r_op[3]),
        .i_mask   (r_mask[3]),
        .i_vals   (r_vals[3]),
        .i_flip   (r_f3),
        .o_cmask  (w_cmask),
        .o_slot   (w_slot)
    );

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r_cmask <= w_cmask;
            r_slot  <= w_slot;
            r_f4    <= r_f3;
        end
    end

    // stage 5: compaction into the output register
    logic [COUNT_W-1:0] w_count;
    logic [FIELD_W-1:0] w_packed [N_CHILD];
    logic [OUT_TDATA_W-1:0] n_tdata;
    logic [OUT_TDATA_W-1:0] r_tdata;

    onmc_compact #(.CHILD_WIDTH(CHILD_WIDTH)) u_compact (
        .i_cmask  (r_cmask),
        .i_slot   (r_slot),
        .o_count  (w_count),
        .o_packed (w_packed)
    );

    always_comb begin
        n_tdata = '0;
        n_tdata[FLIP_W-1:0]                    = r_f4;
        n_tdata[FLIP_W +: MASK_W]              = r_cmask;
        n_tdata[FLIP_W + MASK_W +: COUNT_W]    = w_count;
        for (int i = 0; i < N_CHILD; i++) begin
            n_tdata[FLIP_W + MASK_W + COUNT_W + i*FIELD_W +: FIELD_W] = w_packed[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[5]) r_tdata <= n_tdata;
    end

    assign o_m_axis_tdata = r_tdata;

endmodule

`default_nettype wire

>>> bench/octree_node_mirror_canonicalizer_top_test.sv
// Self-checking bench for the octree node mirror canonicalizer: random and directed nodes.
module octree_node_mirror_canonicalizer_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import onmc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 20;     // idle wait after the final drain
    localparam int LONG_HOLD   = 80;     // receiver hold-off, well past pipe depth

    // Expected output of one node.
    typedef struct packed {
        logic [2:0]       flip;
        logic [7:0]       mask;
        logic [3:0]       count;
        logic [7:0][31:0] kids;
    } t_canon;

    // Predicts the canonical form of each accepted node and checks results in order.
    class canon_board;
        t_canon     canon_q[$];
        int         mismatches;
        int         nodes_noted;
        int         leaf_nodes;
        int         results_checked;
        logic [7:0] flips_seen;

        function new();
            mismatches      = 0;
            nodes_noted     = 0;
            leaf_nodes      = 0;
            results_checked = 0;
            flips_seen      = '0;
        endfunction

        // Bit i of the result comes from bit i^f of the source.
        function logic [7:0] swap_axes(logic [7:0] m, logic [2:0] f);
            logic [7:0] r;
            for (int i = 0; i < 8; i++) r[i] = m[3'(i) ^ f];
            return r;
        endfunction

        function logic [31:0] morph(t_opcode op, logic [31:0] v, logic [2:0] f);
            if (op == OP_LEAF) return {24'd0, swap_axes(v[7:0], f)};
            return v ^ {29'd0, f};
        endfunction

        // Sort key of slot i under flip f; an absent child ranks above any value.
        function logic [40:0] slot_key(t_opcode op, logic [7:0] occ,
                                       logic [7:0][31:0] kids, logic [2:0] f, int i);
            logic [2:0] src;
            src = 3'(i) ^ f;
            if (!occ[src]) return 41'd1 << 40;
            return {9'd0, morph(op, kids[src], f)};
        endfunction

        function t_canon predict_canon(t_opcode op, logic [7:0] occ,
                                       logic [7:0][31:0] kids);
            t_canon     r;
            logic [2:0] best;
            logic [40:0] ka, kb;
            int         cnt;
            best = 3'd0;
            for (int f = 1; f < 8; f++) begin
                for (int i = 0; i < 8; i++) begin
                    ka = slot_key(op, occ, kids, 3'(f), i);
                    kb = slot_key(op, occ, kids, best, i);
                    if (ka < kb) begin
                        best = 3'(f);
                        break;
                    end
                    if (ka > kb) break;
                end
            end
            r.flip = best;
            r.mask = swap_axes(occ, best);
            r.kids = '0;
            cnt = 0;
            for (int i = 0; i < 8; i++) begin
                if (r.mask[i]) begin
                    r.kids[cnt] = morph(op, kids[3'(i) ^ best], best);
                    cnt++;
                end
            end
            r.count = 4'(cnt);
            return r;
        endfunction

        function void note_node(t_opcode op, logic [7:0] occ, logic [7:0][31:0] kids);
            canon_q.insert(canon_q.size(), predict_canon(op, occ, kids));
            nodes_noted++;
            if (op == OP_LEAF) leaf_nodes++;
        endfunction

        function void check_canon(logic [OUT_TDATA_W-1:0] d);
            t_canon want;
            t_canon got;
            got.flip  = d[2:0];
            got.mask  = d[10:3];
            got.count = d[14:11];
            for (int k = 0; k < 8; k++) got.kids[k] = d[15 + 32*k +: 32];
            if (canon_q.size() == 0) begin
                $error("result with no node pending: flip %0d mask %h", got.flip, got.mask);
                mismatches++;
                return;
            end
            want = canon_q.pop_front();
            results_checked++;
            flips_seen[got.flip] = 1'b1;
            if (got.flip !== want.flip) begin
                $error("chosen_flip: expected %0d, got %0d", want.flip, got.flip);
                mismatches++;
            end
            if (got.mask !== want.mask) begin
                $error("canonical_mask: expected %h, got %h", want.mask, got.mask);
                mismatches++;
            end
            if (got.count !== want.count) begin
                $error("child_count: expected %0d, got %0d", want.count, got.count);
                mismatches++;
            end
            for (int k = 0; k < 8; k++) begin
                if (got.kids[k] !== want.kids[k]) begin
                    $error("packed_%0d: expected %h, got %h", k, want.kids[k], got.kids[k]);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return canon_q.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [IN_TDATA_W-1:0]  s_data = '0;
    logic [0:0]             s_user = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_data;

    canon_board board;
    bit         src_idle_on  = 1'b1;
    bit         sink_idle_on = 1'b1;
    int         sink_hold_req = 0;
    int         cycles = 0;

    octree_node_mirror_canonicalizer_top u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // [7:0] occupancy_mask, [39:8] child_0 ... child_7
        .i_s_axis_tuser  (s_user),   // [0] opcode
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)    // flip, mask, count, packed_0 ... packed_7
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("octree_node_mirror_canonicalizer_top verification failed");
            $finish;
        end
    end

    // Offer one node after a random gap, hold it until taken.
    task automatic send_node(t_opcode op, logic [7:0] occ, logic [7:0][31:0] kids);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 4) : 0;
        @(negedge clk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {kids, occ};
        s_user  <= op;
        do @(posedge clk); while (!s_ready);
        board.note_node(op, occ, kids);
    endtask

    task automatic random_node(output t_opcode op, output logic [7:0] occ,
                               output logic [7:0][31:0] kids);
        int          mode;
        logic [31:0] base;
        op = t_opcode'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0:       occ = 8'h00;
            1:       occ = 8'hFF;
            2:       occ = 8'h01 << $urandom_range(0, 7);
            3:       occ = 8'($urandom & $urandom);
            default: occ = 8'($urandom);
        endcase
        // shared upper bits make the flip xor in the low bits decide the order
        base = $urandom_range(0, 32'hFFFF_FFF0) & ~32'h7;
        mode = $urandom_range(0, 3);
        for (int i = 0; i < 8; i++) begin
            case (mode)
                0:       kids[i] = base;
                1:       kids[i] = base | $urandom_range(0, 7);
                default: begin
                    case ($urandom_range(0, 3))
                        0:       kids[i] = $urandom_range(0, 15);
                        1:       kids[i] = base | $urandom_range(0, 7);
                        2:       kids[i] = 32'hFFFF_FFF0 + $urandom_range(0, 14);
                        default: kids[i] = $urandom_range(0, 32'hFFFF_FFFE);
                    endcase
                end
            endcase
        end
    endtask

    task automatic send_random(int n);
        t_opcode          op;
        logic [7:0]       occ;
        logic [7:0][31:0] kids;
        repeat (n) begin
            random_node(op, occ, kids);
            send_node(op, occ, kids);
        end
    endtask

    // Sender goes idle, then waits for every expected result.
    task automatic wait_drained();
        @(negedge clk);
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
    endtask

    task automatic run_directed();
        logic [7:0][31:0] kids;
        // empty nodes: every flip ties
        send_node(OP_INTERIOR, 8'h00, {8{32'hDEAD_BEEF}});
        send_node(OP_LEAF, 8'h00, {8{32'h0000_00FF}});
        // full nodes at the value extremes
        send_node(OP_INTERIOR, 8'hFF, {8{32'h0}});
        send_node(OP_INTERIOR, 8'hFF, {8{32'hFFFF_FFFE}});
        for (int i = 0; i < 8; i++) kids[i] = 32'(i);
        send_node(OP_INTERIOR, 8'hFF, kids);    // identical sequence under every flip
        for (int i = 0; i < 8; i++) kids[i] = 32'hFFFF_FFF0 | i;
        send_node(OP_INTERIOR, 8'hFF, kids);
        // leaf-level: all-ones masks, high bits that must be ignored
        send_node(OP_LEAF, 8'hFF, {8{32'hFFFF_FEFF}});
        for (int i = 0; i < 8; i++) kids[i] = 32'hABCD_1200 | (32'h1 << i);
        send_node(OP_LEAF, 8'hFF, kids);
        send_node(OP_LEAF, 8'hFF, {8{32'h7FFF_FF00}});
        send_node(OP_LEAF, 8'h80, {8{32'hFFFF_FE01}});
        // one child at each position
        for (int p = 0; p < 8; p++) begin
            kids = {8{32'h0}};
            kids[p] = 32'h1234_5670 | p;
            send_node(OP_INTERIOR, 8'h01 << p, kids);
        end
        kids = {8{32'hFFFF_FFF8}};
        kids[3] = 32'h0;
        send_node(OP_INTERIOR, 8'h3C, kids);
        kids = {8{32'h0}};
        kids[0] = 32'd5;
        kids[7] = 32'd2;
        send_node(OP_INTERIOR, 8'h81, kids);
    endtask

    // Receiver: random stall before each item, long hold-off on request.
    initial begin
        int stall;
        wait (rst_n === 1'b1);
        forever begin
            if (sink_hold_req > 0) begin
                stall = sink_hold_req;
                sink_hold_req = 0;
            end else begin
                stall = sink_idle_on ? $urandom_range(0, 4) : 0;
            end
            @(negedge clk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_ready <= 1'b1;
            do @(posedge clk); while (!m_valid);
            board.check_canon(m_data);
        end
    end

    initial begin
        board = new();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        send_random(700);

        // back to back on both sides
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        send_random(400);

        // receiver holds off while the sender keeps offering: pipe fills, input stalls
        wait_drained();
        sink_hold_req = LONG_HOLD;
        send_random(40);
        wait_drained();

        // sender idles only, then receiver only, then both
        src_idle_on = 1'b1;
        send_random(280);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b1;
        send_random(280);
        src_idle_on = 1'b1;
        send_random(280);

        @(negedge clk);
        s_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Covered %0d nodes (%0d leaf-level), %0d results checked, flips chosen %b.",
                 board.nodes_noted, board.leaf_nodes, board.results_checked,
                 board.flips_seen);
        if (board.mismatches == 0) begin
            $display("octree_node_mirror_canonicalizer_top verification clean");
        end else begin
            $display("octree_node_mirror_canonicalizer_top verification failed");
        end
        $finish;
    end

endmodule
